### src/icmper_pkg.sv
// shared types and constants for the icmp echo reply rewriter
package icmper_pkg;

    // operation codes of an input beat
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_PULL = 1'b1;

    // one classified command from the front part to the back part
    typedef struct packed {
        logic       op;
        logic [7:0] data;
        logic       last;
    } t_cmd;

    // back part states
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_SWAP  = 5'b00100,
        ST_SUM   = 5'b01000,
        ST_READY = 5'b10000
    } t_state;

endpackage

### src/icmp_echo_reply_rewriter_unit.sv
// Top level of the ICMP echo reply rewriter. Push beats (operation 0) store an
// Ethernet frame one byte per cycle while the back part takes them; the beat
// marked last starts a check and, for an IPv4 ICMP echo request, an in-place
// rewrite into an echo reply. The rewrite sequencer on the frame memory runs
// the check and the swaps, then sums the header and ICMP bytes, with a setup
// and write back for each checksum, during which beats wait in the four-entry
// front queue. Pull beats (operation 1) read the frame out one byte at a time;
// a new pull waits until the registered memory read of the last one is done.
// A pull with no complete frame waiting gives no result.
module icmp_echo_reply_rewriter_unit #(
    parameter int MAX_FRAME = 2048
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic       i_operation,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic       o_was_reply
);
    import icmper_pkg::*;

    t_cmd w_in_cmd, w_cmd;
    logic w_cmd_valid, w_cmd_take, w_res_valid;

    assign w_in_cmd = '{op: i_operation, data: i_data_byte, last: i_last_byte};

    // front queue
    icmper_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_cmd(w_in_cmd),
        .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd), .i_cmd_take(w_cmd_take)
    );

    // back part
    icmper_back #(.MAX_FRAME(MAX_FRAME)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd),
        .o_cmd_take(w_cmd_take), .o_res_valid(w_res_valid), .i_res_take(pop),
        .o_out_byte, .o_out_last, .o_was_reply
    );

    assign empty = !w_res_valid;

    // a held result keeps its byte while not popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_byte))
        else $error("result changed while waiting");

    // queue cannot be full right after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !full && empty)
        else $error("not empty after reset");
endmodule

### src/icmper_front.sv
// front part: accepts input beats into a short command queue
module icmper_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  icmper_pkg::t_cmd   i_cmd,
    output logic               o_cmd_valid,
    output icmper_pkg::t_cmd   o_cmd,
    input  logic               i_cmd_take
);
    import icmper_pkg::*;

    t_cmd       r_q [4];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_cnt;
    logic       w_in, w_out;

    assign o_full      = (r_cnt == 3'd4);
    assign o_cmd_valid = (r_cnt != 3'd0);
    assign o_cmd       = r_q[r_rd];
    assign w_in        = i_push && !o_full;
    assign w_out       = o_cmd_valid && i_cmd_take;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_in) r_q[r_wr] <= i_cmd;
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_cnt <= '0;
        end else begin
            if (w_in) r_wr <= r_wr + 2'd1;
            if (w_out) r_rd <= r_rd + 2'd1;
            r_cnt <= r_cnt + {2'b0, w_in} - {2'b0, w_out};
        end
    end
endmodule

### src/icmper_back.sv
// back part: frame memory, check and rewrite sequencer, read out
module icmper_back #(
    parameter int MAX_FRAME = 2048
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  icmper_pkg::t_cmd i_cmd,
    output logic             o_cmd_take,
    output logic             o_res_valid,
    input  logic             i_res_take,
    output logic [7:0]       o_out_byte,
    output logic             o_out_last,
    output logic             o_was_reply
);
    import icmper_pkg::*;

    localparam int AW = $clog2(MAX_FRAME);
    localparam int LW = $clog2(MAX_FRAME + 1);

    logic [7:0] r_mem [MAX_FRAME];
    logic [7:0] r_mac [12];     // copy of the mac addresses, bytes 0..11
    logic [7:0] r_ipa [8];      // copy of the ip addresses, bytes 26..33
    logic [7:0] r_et_hi, r_et_lo, r_vihl, r_tl_hi, r_tl_lo, r_proto;
    logic [7:0] r_icmp_type;    // byte at the icmp offset
    t_state     r_state;
    logic [LW-1:0] r_len, r_ridx;
    logic       r_flag;
    // checksum sequencer
    logic [5:0] r_step;
    logic [15:0] r_ih;          // ip header length in bytes
    logic [15:0] r_tot;
    logic [LW-1:0] r_pos, r_end;
    logic       r_phase;        // 0 header sum, 1 icmp sum
    logic       r_hi;           // next memory byte is a high byte
    logic [7:0] r_hb;
    logic [7:0] r_lb;
    logic [31:0] r_sum;
    logic       r_rdv;          // memory read issued last cycle
    logic       r_rdlast;       // that read was the final one
    logic [7:0] r_rdata;
    // write port
    logic          w_we;
    logic [AW-1:0] w_wa;
    logic [7:0]    w_wd;
    logic [AW-1:0] w_ra;
    // output register
    logic       r_ov;
    logic [7:0] r_ob;
    logic       r_ol, r_or;
    logic       r_pend;         // memory read for output in flight
    logic       r_plast;

    function automatic logic [15:0] fold(input logic [31:0] s);
        logic [31:0] t;
        t = {16'b0, s[15:0]} + {16'b0, s[31:16]};
        t = {16'b0, t[15:0]} + {16'b0, t[31:16]};
        return ~t[15:0];
    endfunction

    // frame length limit check
    logic w_push, w_pull, w_room;
    assign w_room = (r_len < LW'(MAX_FRAME));
    logic w_rdy_free;
    assign w_rdy_free = !r_ov || i_res_take;
    always_comb begin
        o_cmd_take = 1'b0;
        if (r_state == ST_IDLE) o_cmd_take = 1'b1;
        if (r_state == ST_READY)
            o_cmd_take = (i_cmd.op == OP_PUSH) ? !r_pend : (!r_pend && w_rdy_free);
    end
    assign w_push = i_cmd_valid && o_cmd_take && i_cmd.op == OP_PUSH;
    assign w_pull = i_cmd_valid && o_cmd_take && i_cmd.op == OP_PULL
                    && r_state == ST_READY;

    // check results from the header copy
    logic [15:0] w_hl, w_totv;
    logic        w_ok;
    always_comb begin
        w_hl  = {10'b0, r_vihl[3:0], 2'b0};
        w_totv = {r_tl_hi, r_tl_lo};
        w_ok = (r_len >= LW'(34)) && r_et_hi == 8'h08 && r_et_lo == 8'h00
            && r_vihl[7:4] == 4'd4 && w_hl >= 16'd20
            && (32'd14 + 32'(w_hl)) <= 32'(r_len) && r_proto == 8'd1
            && (32'(w_totv) >= 32'(w_hl) + 32'd4)
            && (32'd14 + 32'(w_totv)) <= 32'(r_len)
            && r_icmp_type == 8'd8;
    end

    // swap step map: each mac and ip address step s writes byte s from its partner
    function automatic logic [5:0] partner(input logic [5:0] s);
        if (s < 6'd6) return s + 6'd6;
        if (s < 6'd12) return s - 6'd6;
        if (s < 6'd30) return s + 6'd4;
        return s - 6'd4;
    endfunction

    // memory write selection
    always_comb begin
        w_we = 1'b0; w_wa = '0; w_wd = '0;
        if (w_push && (r_state == ST_IDLE || r_state == ST_READY)) begin
            w_we = (r_state == ST_READY) ? 1'b1 : w_room;
            w_wa = (r_state == ST_READY) ? '0 : r_len[AW-1:0];
            w_wd = i_cmd.data;
        end else if (r_state == ST_SWAP) begin
            w_we = 1'b1;
            w_wa = AW'(r_step);
            if (r_step == 6'd24 || r_step == 6'd25) w_wd = 8'd0;
            else if (r_step < 6'd12)
                w_wd = r_mac[4'(partner(r_step))];
            else if (r_step >= 6'd26 && r_step < 6'd34)
                w_wd = r_ipa[3'(partner(r_step) - 6'd26)];
            else if (r_step == 6'd34) begin
                w_wa = AW'(32'd14 + 32'(r_ih)); w_wd = 8'd0;
            end else if (r_step == 6'd35) begin
                w_wa = AW'(32'd16 + 32'(r_ih)); w_wd = 8'd0;
            end else begin
                w_wa = AW'(32'd17 + 32'(r_ih)); w_wd = 8'd0;
            end
        end else if (r_state == ST_SUM && r_step == 6'd1) begin
            w_we = 1'b1; w_wa = AW'(24); w_wd = r_hb;
        end else if (r_state == ST_SUM && r_step == 6'd2) begin
            w_we = 1'b1; w_wa = AW'(25); w_wd = r_lb;
        end else if (r_state == ST_SUM && r_step == 6'd3) begin
            w_we = 1'b1; w_wa = AW'(32'd16 + 32'(r_ih)); w_wd = r_hb;
        end else if (r_state == ST_SUM && r_step == 6'd4) begin
            w_we = 1'b1; w_wa = AW'(32'd17 + 32'(r_ih)); w_wd = r_lb;
        end
    end

    // memory read address
    always_comb begin
        w_ra = r_ridx[AW-1:0];
        if (r_state == ST_SUM) w_ra = r_pos[AW-1:0];
    end

    // frame memory
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        r_rdata <= r_mem[w_ra];
    end

    // header copy: fields the check and the swaps need, loaded by push beats
    logic [31:0] w_wa_x;
    assign w_wa_x = {{(32-AW){1'b0}}, w_wa};
    always_ff @(posedge i_clk) begin
        if (w_push && w_we) begin
            if (w_wa_x < 32'd12) r_mac[w_wa[3:0]] <= w_wd;
            if (w_wa_x >= 32'd26 && w_wa_x < 32'd34) r_ipa[3'(w_wa_x - 32'd26)] <= w_wd;
            if (w_wa_x == 32'd12) r_et_hi <= w_wd;
            if (w_wa_x == 32'd13) r_et_lo <= w_wd;
            if (w_wa_x == 32'd14) r_vihl <= w_wd;
            if (w_wa_x == 32'd16) r_tl_hi <= w_wd;
            if (w_wa_x == 32'd17) r_tl_lo <= w_wd;
            if (w_wa_x == 32'd23) r_proto <= w_wd;
            if (w_wa_x == 32'd14 + 32'(w_hl)) r_icmp_type <= w_wd;
        end
    end

    // sequencer and read out
    logic w_issue;
    assign w_issue = (r_state == ST_SUM) && r_step == 6'd0 && r_pos != r_end;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_len <= '0; r_ridx <= '0; r_flag <= 1'b0;
            r_ov <= 1'b0; r_pend <= 1'b0; r_step <= '0; r_rdv <= 1'b0;
        end else begin
            r_rdv <= w_issue;
            r_rdlast <= w_issue && (r_pos + LW'(1) == r_end);
            if (r_ov && i_res_take) r_ov <= 1'b0;
            if (r_pend) begin
                r_pend <= 1'b0;
                r_ov <= 1'b1; r_ob <= r_rdata; r_ol <= r_plast;
                if (r_plast) begin
                    r_state <= ST_IDLE; r_len <= '0; r_ridx <= '0; r_flag <= 1'b0;
                    r_or <= r_flag;
                end else r_or <= r_flag;
            end
            case (r_state)
                ST_IDLE, ST_READY: begin
                    if (w_push) begin
                        if (r_state == ST_READY) begin
                            r_len <= LW'(1); r_ridx <= '0; r_flag <= 1'b0;
                        end else if (w_room) r_len <= r_len + LW'(1);
                        r_state <= i_cmd.last ? ST_CHECK : ST_IDLE;
                    end else if (w_pull) begin
                        r_pend <= 1'b1;
                        r_plast <= (r_ridx + LW'(1) == r_len);
                        r_ridx <= r_ridx + LW'(1);
                    end
                end
                ST_CHECK: begin
                    r_ridx <= '0;
                    r_flag <= 1'b0;
                    if (w_ok) begin
                        r_ih <= w_hl; r_tot <= w_totv;
                        r_step <= '0; r_state <= ST_SWAP;
                    end else r_state <= (r_len == '0) ? ST_IDLE : ST_READY;
                end
                ST_SWAP: begin
                    if (r_step == 6'd11) r_step <= 6'd24;
                    else if (r_step == 6'd36) begin
                        r_step <= '0; r_state <= ST_SUM; r_phase <= 1'b0;
                        r_pos <= LW'(14); r_end <= LW'(32'd14 + 32'(r_ih));
                        r_sum <= '0; r_hi <= 1'b1;
                    end else r_step <= r_step + 6'd1;
                end
                ST_SUM: begin
                    if (r_step == 6'd0) begin
                        if (w_issue) r_pos <= r_pos + LW'(1);
                        if (r_rdv) begin
                            if (r_hi) begin
                                r_sum <= r_sum + {16'b0, r_rdata, 8'b0};
                                r_hi <= 1'b0;
                            end else begin
                                r_sum <= r_sum + {24'b0, r_rdata};
                                r_hi <= 1'b1;
                            end
                        end
                        if (r_rdv && r_rdlast) r_step <= 6'd5;
                    end else if (r_step == 6'd5) begin
                        {r_hb, r_lb} <= fold(r_sum);
                        r_step <= r_phase ? 6'd3 : 6'd1;
                    end else if (r_step == 6'd1) r_step <= 6'd2;
                    else if (r_step == 6'd2) begin
                        r_step <= '0; r_phase <= 1'b1; r_sum <= '0; r_hi <= 1'b1;
                        r_pos <= LW'(32'd14 + 32'(r_ih));
                        r_end <= LW'(32'd14 + 32'(r_tot));
                    end else if (r_step == 6'd3) r_step <= 6'd4;
                    else begin
                        r_step <= '0; r_flag <= 1'b1; r_state <= ST_READY;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_res_valid = r_ov;
    assign o_out_byte  = r_ob;
    assign o_out_last  = r_ol;
    assign o_was_reply = r_or;
endmodule

### tb/sv/icmp_echo_reply_rewriter_unit_tb.sv
// testbench for the icmp echo reply rewriter: frame push/pull beats checked against a predictor
`timescale 1ns / 1ps

module icmp_echo_reply_rewriter_unit_tb;
    import icmper_pkg::*;

    localparam int MAX_FRAME = 2048;

    typedef struct {
        logic       op;
        logic [7:0] data;
        logic       last;
    } t_beat;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       reply;
    } t_out_beat;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic       i_operation;
    logic [7:0] i_data_byte;
    logic       i_last_byte;
    logic       empty;
    logic       pop;
    logic [7:0] o_out_byte;
    logic       o_out_last;
    logic       o_was_reply;

    icmp_echo_reply_rewriter_unit #(.MAX_FRAME(MAX_FRAME)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_operation (i_operation),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .empty       (empty),
        .pop         (pop),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .o_was_reply (o_was_reply)
    );

    // predictor state
    logic [7:0] frm_mem [MAX_FRAME];
    int unsigned frm_len;
    int unsigned rd_idx;
    bit          frm_ready;
    bit          frm_reply;

    t_beat     beat_q[$];
    t_out_beat reply_bytes_q[$];
    int        err_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    bit        send_hold;
    bit        stim_done;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic int unsigned sum_words(int unsigned start, int unsigned count);
        int unsigned acc;
        int unsigned i;
        acc = 0;
        i = 0;
        while (i + 1 < count) begin
            acc += {frm_mem[start + i], frm_mem[start + i + 1]};
            i += 2;
        end
        if (i < count) acc += {frm_mem[start + i], 8'h00};
        return acc;
    endfunction

    function automatic logic [15:0] fold_sum(int unsigned s);
        s = (s & 32'hffff) + (s >> 16);
        s = (s & 32'hffff) + (s >> 16);
        return ~s[15:0];
    endfunction

    // check the finished frame and rewrite an echo request in place
    function automatic void rewrite_frame();
        int unsigned hl, tot, ic;
        logic [7:0] t;
        logic [15:0] c;
        frm_reply = 1'b0;
        if (frm_len < 34) return;
        if (frm_mem[12] != 8'h08 || frm_mem[13] != 8'h00) return;
        if (frm_mem[14][7:4] != 4'd4) return;
        hl = frm_mem[14][3:0] * 4;
        if (hl < 20 || 14 + hl > frm_len) return;
        if (frm_mem[23] != 8'd1) return;
        tot = {frm_mem[16], frm_mem[17]};
        if (tot < hl + 4 || 14 + tot > frm_len) return;
        ic = 14 + hl;
        if (frm_mem[ic] != 8'd8) return;
        for (int i = 0; i < 6; i++) begin
            t = frm_mem[i]; frm_mem[i] = frm_mem[6 + i]; frm_mem[6 + i] = t;
        end
        for (int i = 0; i < 4; i++) begin
            t = frm_mem[26 + i]; frm_mem[26 + i] = frm_mem[30 + i]; frm_mem[30 + i] = t;
        end
        frm_mem[ic] = 8'd0;
        frm_mem[24] = 8'd0;
        frm_mem[25] = 8'd0;
        c = fold_sum(sum_words(14, hl));
        frm_mem[24] = c[15:8];
        frm_mem[25] = c[7:0];
        frm_mem[ic + 2] = 8'd0;
        frm_mem[ic + 3] = 8'd0;
        c = fold_sum(sum_words(ic, tot - hl));
        frm_mem[ic + 2] = c[15:8];
        frm_mem[ic + 3] = c[7:0];
        frm_reply = 1'b1;
    endfunction

    // advance the predictor by one accepted beat
    function automatic void predict_beat(t_beat b);
        t_out_beat o;
        if (b.op == OP_PUSH) begin
            if (frm_ready) begin
                frm_ready = 0; frm_len = 0; rd_idx = 0; frm_reply = 0;
            end
            if (frm_len < MAX_FRAME) begin
                frm_mem[frm_len] = b.data;
                frm_len++;
            end
            if (b.last) begin
                rewrite_frame();
                frm_ready = 1;
                rd_idx = 0;
            end
        end else if (frm_ready && rd_idx < frm_len) begin
            o.data = frm_mem[rd_idx];
            o.last = (rd_idx + 1 == frm_len);
            o.reply = frm_reply;
            reply_bytes_q.push_back(o);
            rd_idx++;
            if (rd_idx >= frm_len) begin
                frm_ready = 0; frm_len = 0; rd_idx = 0; frm_reply = 0;
            end
        end
    endfunction

    task automatic add_beat(logic op, logic [7:0] d, logic l);
        t_beat b;
        b.op = op; b.data = d; b.last = l;
        beat_q.push_back(b);
    endtask

    task automatic add_pulls(int n);
        for (int i = 0; i < n; i++) add_beat(OP_PULL, 8'($urandom), 1'($urandom));
    endtask

    // build a frame; well-formed echo request unless corrupt picks a field to break
    task automatic add_frame(int ihl, int pay, int corrupt, int extra);
        logic [7:0] f[$];
        int tot;
        tot = ihl * 4 + 4 + pay;
        for (int i = 0; i < 12; i++) f.push_back(8'($urandom));
        f.push_back(8'h08); f.push_back(8'h00);
        f.push_back({4'd4, 4'(ihl)});
        f.push_back(8'($urandom));
        f.push_back(8'(tot >> 8)); f.push_back(8'(tot));
        for (int i = 18; i < 23; i++) f.push_back(8'($urandom));
        f.push_back(8'd1);
        for (int i = 24; i < 14 + ihl * 4; i++) f.push_back(8'($urandom));
        f.push_back(8'd8);
        for (int i = 1; i < 4 + pay + extra; i++) f.push_back(8'($urandom));
        while (f.size() < 34) f.push_back(8'($urandom));
        case (corrupt)
            1: f[12] = 8'($urandom);
            2: f[13] = 8'($urandom_range(1, 255));
            3: f[14][7:4] = 4'($urandom);
            4: f[23] = 8'($urandom);
            5: f[14 + ihl * 4] = 8'($urandom);
            6: f[17] = 8'($urandom);
            7: f[16] = 8'($urandom_range(1, 255));
            8: f[14][3:0] = 4'($urandom_range(0, 4));
            default: ;
        endcase
        foreach (f[i]) add_beat(OP_PUSH, f[i], i == f.size() - 1);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push        <= 1'b0;
            i_operation <= OP_PUSH;
            i_data_byte <= 8'h00;
            i_last_byte <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_beat('{i_operation, i_data_byte, i_last_byte});
                void'(beat_q.pop_front());
            end
            if (beat_q.size() > 0 && !send_hold && $urandom_range(0, 99) >= send_idle_pct) begin
                push        <= 1'b1;
                i_operation <= beat_q[0].op;
                i_data_byte <= beat_q[0].data;
                i_last_byte <= beat_q[0].last;
            end else if (!(push && full)) begin
                push <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (reply_bytes_q.size() == 0) begin
                    report_mismatch("unexpected beat", o_out_byte, 0);
                end else begin
                    if (o_out_byte !== reply_bytes_q[0].data)
                        report_mismatch("out_byte", o_out_byte, reply_bytes_q[0].data);
                    if (o_out_last !== reply_bytes_q[0].last)
                        report_mismatch("out_last", o_out_last, reply_bytes_q[0].last);
                    if (o_was_reply !== reply_bytes_q[0].reply)
                        report_mismatch("was_reply", o_was_reply, reply_bytes_q[0].reply);
                    void'(reply_bytes_q.pop_front());
                end
            end
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // stimulus and end of run
    initial begin
        int len;
        i_rst_n = 1'b0;
        err_count = 0; send_hold = 0; stim_done = 0;
        send_idle_pct = 20; recv_idle_pct = 72;
        frm_len = 0; rd_idx = 0; frm_ready = 0; frm_reply = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: pull with nothing ready, minimal echo, short frame, push while ready
        add_pulls(2);
        add_frame(5, 0, 0, 0);
        add_pulls(40);
        add_beat(OP_PUSH, 8'hff, 1'b0);
        add_beat(OP_PUSH, 8'h00, 1'b1);
        add_pulls(3);
        add_frame(5, 1, 0, 1);
        add_pulls(5);
        add_frame(15, 3, 0, 0);
        add_pulls(100);
        // random: mostly echo requests, some broken frames and noise
        for (int ph = 0; ph < 3; ph++) begin
            while (beat_q.size() < 100) begin
                case ($urandom_range(0, 9))
                    0: begin
                        len = $urandom_range(1, 40);
                        for (int i = 0; i < len; i++)
                            add_beat(OP_PUSH, 8'($urandom), i == len - 1);
                    end
                    1, 2: add_frame($urandom_range(5, 15), $urandom_range(0, 12),
                                    $urandom_range(1, 8), $urandom_range(0, 3));
                    default: add_frame($urandom_range(5, 7), $urandom_range(0, 9), 0,
                                       $urandom_range(0, 2));
                endcase
                add_pulls($urandom_range(0, 1) ? 90 : $urandom_range(0, 30));
            end
            wait (beat_q.size() == 0);
            // let everything drain, sender held off
            send_hold = 1;
            wait (reply_bytes_q.size() == 0);
            repeat (50) @(posedge i_clk);
            send_hold = 0;
            if (ph == 0) begin send_idle_pct = 72; recv_idle_pct = 20; end
            else begin send_idle_pct = 0; recv_idle_pct = 0; end
        end
        wait (beat_q.size() == 0);
        wait (reply_bytes_q.size() == 0);
        repeat (100) @(posedge i_clk);
        if (err_count == 0 && reply_bytes_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // timeout
    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### icmp_echo_reply_rewriter_unit.f
src/icmper_pkg.sv
src/icmper_front.sv
src/icmper_back.sv
src/icmp_echo_reply_rewriter_unit.sv
tb/sv/icmp_echo_reply_rewriter_unit_tb.sv
